// File: rtl/core/osb_pkg.sv
// Shared constants, codes and types of the one-shot timer bank.
`default_nettype none

package osb_pkg;

  // Bank size and the widths that follow from it.
  localparam int SLOTS  = 16;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  // Field widths of the input and result words.
  localparam int MODE_W = 2;
  localparam int TAG_W  = 16;
  localparam int TIME_W = 32;
  localparam int OCC_W  = 5;

  // Operation codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // Result kinds.
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_COUNT,
    S_RUN,
    S_STATUS
  } osb_state_t;

  // Contents of one timer cell.
  typedef struct packed {
    logic [TIME_W-1:0] remain;
    logic [TAG_W-1:0]  tag;
    logic              fire;
  } cell_data_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic shift;
    logic load;
    logic flag;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/osb_ifs.sv
// Handshake interfaces for the input and result channels of the timer bank.
`default_nettype none

interface osb_req_if import osb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [TAG_W-1:0]  event_tag;
  logic [TIME_W-1:0] delay_amount;
  logic [TIME_W-1:0] tick_amount;

  modport source (output valid, output mode, output event_tag,
                  output delay_amount, output tick_amount, input ready);
  modport sink   (input valid, input mode, input event_tag,
                  input delay_amount, input tick_amount, output ready);
endinterface

interface osb_rsp_if import osb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             item_kind;
  logic [TAG_W-1:0] fired_tag;
  logic             add_refused;
  logic [OCC_W-1:0] occupancy;
  logic             last_item;

  modport source (output valid, output item_kind, output fired_tag,
                  output add_refused, output occupancy, output last_item,
                  input ready);
  modport sink   (input valid, input item_kind, input fired_tag,
                  input add_refused, input occupancy, input last_item,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/osb_cell.sv
// One timer cell: holds a remaining time, a tag and a fire flag.
`default_nettype none

module osb_cell import osb_pkg::*; (
  input  wire logic              clk,
  input  wire cell_ctrl_t        ctrl,
  input  wire cell_data_t        nbr,
  input  wire cell_data_t        load_data,
  input  wire logic [TIME_W-1:0] elapsed,
  output cell_data_t             q
);

  cell_data_t data;

  // A load takes priority over a shift; the fire flag is evaluated in place.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data <= load_data;
    end else if (ctrl.shift) begin
      data <= nbr;
    end else if (ctrl.flag) begin
      data.fire <= (elapsed > data.remain);
    end
  end

  assign q = data;

endmodule

`default_nettype wire

// File: rtl/core/one_shot_timer_bank_unit.sv
// One-shot timer bank: top level with the cell chain, sequencer and output register.
//
// Usage: words arrive on req (valid/ready) and results leave on rsp (valid/ready).
// A word with mode add appends a timer, tick ages all timers, clear empties the bank.
// Each word produces zero or more fired reports followed by one status word with
// last_item set; every result carries the occupancy left after the operation.
// req.ready is high only while the sequencer is idle, so one word is worked at a time.
// Add, clear and the unused mode code go from idle straight to the status state, which
// loads their status word into the output register once it is free. A tick first flags
// every cell in parallel, counts the survivors, then walks the chain: the head cell is
// examined once a cycle, unless a firing head waits for the output register, and either
// reported or pushed back to the tail of the live region. The status word ends the walk.
// The walk must finish before the next word is accepted. When the receiver stalls, the
// result stays in the output register and the walk pauses at the next timer that fires.
// Reset empties the bank and drops any pending result; the cell contents are not cleared
// and are only read below the held count.
`default_nettype none

module one_shot_timer_bank_unit import osb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  osb_req_if.sink   req,
  osb_rsp_if.source rsp
);

  osb_state_t        state, state_next;
  logic [CNT_W-1:0]  held_count;
  logic [CNT_W-1:0]  qlen;
  logic [CNT_W-1:0]  steps_left;
  logic [CNT_W-1:0]  final_cnt;
  logic              refused;
  logic [TIME_W-1:0] elapsed;

  logic              out_valid;
  logic              out_kind;
  logic [TAG_W-1:0]  out_tag;
  logic              out_refused;
  logic [OCC_W-1:0]  out_occ;
  logic              out_last;

  cell_data_t        cell_q [SLOTS];
  cell_ctrl_t        cell_ctrl [SLOTS];
  cell_data_t        load_data;
  cell_data_t        head;
  logic [SLOTS-1:0]  fire_vec;
  logic [SLOTS-1:0]  live_mask;
  logic [CNT_W-1:0]  fired_cnt;

  logic              accept;
  logic              full;
  logic              out_free;
  logic              step_go;
  logic              emit_rep;
  logic              emit_stat;
  logic              req_ready;

  assign head     = cell_q[0];
  assign full     = (held_count >= CNT_W'(SLOTS));
  assign out_free = !out_valid || rsp.ready;
  assign accept   = req.valid && req_ready;
  assign req.ready = req_ready;

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (req.mode == MODE_TICK) ? S_COUNT : S_STATUS;
        end
      end
      S_COUNT: begin
        state_next = S_RUN;
      end
      S_RUN: begin
        if (steps_left == '0) begin
          state_next = S_STATUS;
        end
      end
      S_STATUS: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    req_ready = 1'b0;
    step_go   = 1'b0;
    emit_rep  = 1'b0;
    emit_stat = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
      end
      S_COUNT: begin
      end
      S_RUN: begin
        step_go  = (steps_left != '0) && (!head.fire || out_free);
        emit_rep = (steps_left != '0) && head.fire && out_free;
      end
      S_STATUS: begin
        emit_stat = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Data loaded into a cell: a new timer on add, the aged head on a survivor push.
  always_comb begin
    if (state == S_IDLE) begin
      load_data.remain = req.delay_amount;
      load_data.tag    = req.event_tag;
    end else begin
      load_data.remain = head.remain - elapsed;
      load_data.tag    = head.tag;
    end
    load_data.fire = 1'b0;
  end

  // Per-cell control and the chain of cells.
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    cell_data_t nbr;

    if (g == SLOTS - 1) begin : g_tail
      assign nbr = cell_q[g];
    end else begin : g_mid
      assign nbr = cell_q[g+1];
    end

    assign cell_ctrl[g].shift = step_go;
    assign cell_ctrl[g].load  =
        (accept && (req.mode == MODE_ADD) && !full && (CNT_W'(g) == held_count)) ||
        (step_go && !head.fire && (CNT_W'(g) == qlen - CNT_W'(1)));
    assign cell_ctrl[g].flag  = accept && (req.mode == MODE_TICK);

    assign fire_vec[g]  = cell_q[g].fire;
    assign live_mask[g] = (CNT_W'(g) < qlen);

    osb_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[g]),
      .nbr       (nbr),
      .load_data (load_data),
      .elapsed   (req.tick_amount),
      .q         (cell_q[g])
    );
  end

  assign fired_cnt = CNT_W'($countones(fire_vec & live_mask));

  // Bank bookkeeping: held count, refusal flag, walk counters, survivor count and the tick amount.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      qlen       <= '0;
      steps_left <= '0;
      final_cnt  <= '0;
      refused    <= 1'b0;
    end else begin
      if (accept) begin
        refused    <= 1'b0;
        qlen       <= held_count;
        steps_left <= held_count;
        case (req.mode)
          MODE_ADD: begin
            if (full) begin
              refused <= 1'b1;
            end else begin
              held_count <= held_count + CNT_W'(1);
            end
          end
          MODE_CLEAR: begin
            held_count <= '0;
          end
          default: begin
          end
        endcase
      end
      if (state == S_COUNT) begin
        final_cnt <= qlen - fired_cnt;
      end
      if (step_go) begin
        steps_left <= steps_left - CNT_W'(1);
        if (head.fire) begin
          qlen <= qlen - CNT_W'(1);
        end
      end
      if ((state == S_RUN) && (steps_left == '0)) begin
        held_count <= qlen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      elapsed <= req.tick_amount;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_rep || emit_stat) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_rep) begin
      out_kind    <= KIND_REPORT;
      out_tag     <= head.tag;
      out_refused <= 1'b0;
      out_occ     <= OCC_W'(final_cnt);
      out_last    <= 1'b0;
    end else if (emit_stat) begin
      out_kind    <= KIND_STATUS;
      out_tag     <= '0;
      out_refused <= refused;
      out_occ     <= OCC_W'(held_count);
      out_last    <= 1'b1;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.item_kind   = out_kind;
  assign rsp.fired_tag   = out_tag;
  assign rsp.add_refused = out_refused;
  assign rsp.occupancy   = out_occ;
  assign rsp.last_item   = out_last;

  // The bank never holds more timers than it has cells.
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CNT_W'(SLOTS))
    else $error("held count exceeds bank size");

  // During the walk the live region always covers the timers still to examine.
  a_walk_cover: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (qlen >= steps_left))
    else $error("live region smaller than remaining walk");

  // At the end of the walk the survivors match the count taken before it.
  a_walk_count: assert property (@(posedge clk) disable iff (rst)
    ((state == S_RUN) && (steps_left == '0)) |-> (qlen == final_cnt))
    else $error("survivor count differs from precount");

  // Reports are never marked last and never carry a refusal.
  a_report_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == KIND_REPORT)) |-> (!out_last && !out_refused))
    else $error("malformed fired report");

  // Only idle accepts a word; an accepted tick always moves the sequencer on to the count state.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.mode == MODE_TICK)) |=> (state == S_COUNT))
    else $error("tick did not start its count");

endmodule

`default_nettype wire
